### rtl/core/hit_rate_meter_unit_defines.svh
// ============================================================================
// Hit rate meter - assertion macros
// Shared property forms for the port-level checker.
// ============================================================================
`ifndef HIT_RATE_METER_UNIT_DEFINES_SVH
`define HIT_RATE_METER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define HRM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define HRM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/hrm_pkg.sv
// ============================================================================
// Hit rate meter - package
// Shared constants, register indexes, sequencer states and divider types.
// ============================================================================
package hrm_pkg;

    // Hit time ring
    localparam int WINDOW_DEPTH = 16;
    localparam int PTR_W        = $clog2(WINDOW_DEPTH);
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);

    // Field widths
    localparam int TIME_W  = 32;
    localparam int Z_W     = 16;
    localparam int RATE_W  = 16;
    localparam int BAR_W   = 8;
    localparam int KIND_W  = 2;
    localparam int MS_W    = 16;

    // Stream payload widths
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = KIND_W;
    localparam int M_USED_W  = 3 + RATE_W + BAR_W + RATE_W;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_HIT_THRESHOLD    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_HIT_HOLDOFF_MS   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_UPDATE_PERIOD_MS = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_HIT_TIMEOUT_MS   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_HITS_TO_SHOW = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_BAR_LENGTH       = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_FULL_SCALE_RATE  = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_STORED_BEST_RATE = 3'd7;

    // Register reset values
    localparam logic signed [Z_W-1:0] HIT_THRESHOLD_RST = -16'sd17000;
    localparam logic [MS_W-1:0]   HIT_HOLDOFF_RST    = 16'd40;
    localparam logic [MS_W-1:0]   UPDATE_PERIOD_RST  = 16'd400;
    localparam logic [MS_W-1:0]   HIT_TIMEOUT_RST    = 16'd3000;
    localparam logic [CNT_W-1:0]  MIN_HITS_RST       = CNT_W'(7);
    localparam logic [BAR_W-1:0]  BAR_LENGTH_RST     = 8'd60;
    localparam logic [RATE_W-1:0] FULL_SCALE_RST     = 16'd800;
    localparam logic [RATE_W-1:0] STORED_BEST_RST    = 16'd0;

    // Hits per minute from a millisecond span
    localparam int RATE_SCALE = 60000;

    // Record codes
    localparam logic [KIND_W-1:0] REC_NONE = 2'd0;
    localparam logic [KIND_W-1:0] REC_DAY  = 2'd1;
    localparam logic [KIND_W-1:0] REC_ALL  = 2'd2;

    // Shared divider: numerator / quotient width and step counter
    localparam int DIV_W     = 24;
    localparam int DEN_W     = TIME_W;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DEN_W-1:0] den;
    } hrm_div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quo;
    } hrm_div_rsp_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_HIT,
        S_CHK,
        S_RD_NEW,
        S_RD_OLD,
        S_DIVR_GO,
        S_DIVR,
        S_MUL,
        S_DIVB_GO,
        S_DIVB,
        S_TMO,
        S_OUT
    } hrm_state_t;

endpackage

### rtl/core/hrm_ram.sv
// ============================================================================
// Hit rate meter - generic RAM
// One write port, one read port, registered read data.
// ============================================================================
module hrm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/hrm_div.sv
// ============================================================================
// Hit rate meter - shared divider
// Restoring divider, one quotient bit per cycle while busy, DIV_W bits per request.
// ============================================================================
module hrm_div (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  hrm_pkg::hrm_div_req_t req,
    output hrm_pkg::hrm_div_rsp_t rsp
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [hrm_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [hrm_pkg::DEN_W-1:0]     rem_reg, rem_next;
    logic [hrm_pkg::DEN_W-1:0]     den_reg, den_next;
    logic [hrm_pkg::DIV_W-1:0]     quo_reg, quo_next;

    logic [hrm_pkg::DEN_W:0]       trial;
    logic [hrm_pkg::DEN_W:0]       diff;
    logic                          ge;

    // One restoring step: shift in the next numerator bit, try a subtract
    assign trial = {rem_reg, quo_reg[hrm_pkg::DIV_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            den_next  = req.den;
            quo_next  = req.num;
        end else if (busy_reg) begin
            rem_next = ge ? diff[hrm_pkg::DEN_W-1:0] : trial[hrm_pkg::DEN_W-1:0];
            quo_next = {quo_reg[hrm_pkg::DIV_W-2:0], ge};
            cnt_next = cnt_reg + hrm_pkg::DIV_CNT_W'(1);
            if (cnt_reg == hrm_pkg::DIV_CNT_W'(hrm_pkg::DIV_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

### rtl/core/hit_rate_meter_unit.sv
// A request with no rate update due runs S_HIT, S_CHK, S_TMO and S_OUT; one with
// an update due also reads the ring and runs up to two 24-bit divides on the
// shared divider. Requests are handled one at a time, with no overlap.
// Input ready is low from acceptance until the result enters the output register.
// Reset (aresetn low, synchronous): control state cleared, registers to defaults;
// the hit time RAM is not cleared.
// ============================================================================
// Hit rate meter - top level
// Detects hits in Z samples, keeps a ring of hit times, and derives a hit rate,
// a bar level and session records under a small sequencer.
// ============================================================================
module hit_rate_meter_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration writes
    input  logic                            cfg_wr_en,
    input  logic [hrm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [hrm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // Sample stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [hrm_pkg::S_TDATA_W-1:0]   s_tdata,  // accel_z[15:0], time_ms[47:16]
    // Result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [hrm_pkg::M_TDATA_W-1:0]   m_tdata,  // hit_seen[0], bar_updated[1],
                                                      // rate_value[17:2], bar_level[25:18],
                                                      // session_ended[26],
                                                      // record_rate[42:27], zero[47:43]
    output logic [hrm_pkg::M_TUSER_W-1:0]   m_tuser   // record_kind[1:0]
);

    localparam int PW = hrm_pkg::PTR_W;
    localparam int CW = hrm_pkg::CNT_W;

    hrm_pkg::hrm_state_t state_reg, state_next;

    // Configuration registers
    logic signed [hrm_pkg::Z_W-1:0] thr_reg, thr_next;
    logic [hrm_pkg::MS_W-1:0]       holdoff_reg, holdoff_next;
    logic [hrm_pkg::MS_W-1:0]       period_reg, period_next;
    logic [hrm_pkg::MS_W-1:0]       timeout_reg, timeout_next;
    logic [CW-1:0]                  min_hits_reg, min_hits_next;
    logic [hrm_pkg::BAR_W-1:0]      bar_len_reg, bar_len_next;
    logic [hrm_pkg::RATE_W-1:0]     fs_reg, fs_next;

    // Session state
    logic [PW-1:0]                  wpos_reg, wpos_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic [hrm_pkg::TIME_W-1:0]     last_hit_reg, last_hit_next;
    logic [hrm_pkg::TIME_W-1:0]     next_upd_reg, next_upd_next;
    logic                           active_reg, active_next;
    logic [hrm_pkg::RATE_W-1:0]     peak_reg, peak_next;
    logic [hrm_pkg::RATE_W-1:0]     day_best_reg, day_best_next;
    logic [hrm_pkg::RATE_W-1:0]     all_best_reg, all_best_next;
    logic [hrm_pkg::RATE_W-1:0]     last_rate_reg, last_rate_next;
    logic [hrm_pkg::BAR_W-1:0]      last_bar_reg, last_bar_next;

    // Per-request flags
    logic                           hit_flag_reg, hit_flag_next;
    logic                           upd_flag_reg, upd_flag_next;
    logic                           end_flag_reg, end_flag_next;
    logic [hrm_pkg::KIND_W-1:0]     kind_reg, kind_next;
    logic [hrm_pkg::RATE_W-1:0]     krate_reg, krate_next;

    // Working payload
    logic signed [hrm_pkg::Z_W-1:0] z_reg, z_next;
    logic [hrm_pkg::TIME_W-1:0]     now_reg, now_next;
    logic [hrm_pkg::TIME_W-1:0]     newest_reg, newest_next;
    logic [hrm_pkg::RATE_W-1:0]     rate_reg, rate_next;
    logic [hrm_pkg::DIV_W-1:0]      div_num_reg, div_num_next;
    logic [hrm_pkg::DEN_W-1:0]      div_den_reg, div_den_next;

    // Output register
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [hrm_pkg::M_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic [hrm_pkg::M_TUSER_W-1:0]  m_tuser_reg, m_tuser_next;

    // RAM and divider hookup
    logic                           ram_we;
    logic [PW-1:0]                  ram_waddr;
    logic [PW-1:0]                  ram_raddr;
    logic [hrm_pkg::TIME_W-1:0]     ram_rdata;
    hrm_pkg::hrm_div_req_t          div_req;
    hrm_pkg::hrm_div_rsp_t          div_rsp;

    // Decode helpers
    logic [hrm_pkg::TIME_W-1:0]     since_hit;
    logic [hrm_pkg::TIME_W-1:0]     to_update;
    logic [hrm_pkg::TIME_W-1:0]     span;
    logic                           is_hit;
    logic                           update_go;
    logic                           timed_out;
    logic                           can_load;
    logic [PW-1:0]                  wr_idx;
    logic [CW-1:0]                  base_count;
    logic [PW-1:0]                  newest_idx;
    logic [PW-1:0]                  oldest_idx;
    logic [hrm_pkg::RATE_W-1:0]     rate_sat;
    logic [hrm_pkg::BAR_W-1:0]      bar_sat;
    logic                           commit_en;
    logic [hrm_pkg::BAR_W-1:0]      commit_bar;

    // ------------------------------------------------------------------
    // Hit time ring and shared divider
    // ------------------------------------------------------------------
    hrm_ram #(
        .WIDTH (hrm_pkg::TIME_W),
        .DEPTH (hrm_pkg::WINDOW_DEPTH)
    ) u_hrm_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (now_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    hrm_div u_hrm_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // ------------------------------------------------------------------
    // Decode
    // ------------------------------------------------------------------
    assign since_hit = now_reg - last_hit_reg;
    assign to_update = now_reg - next_upd_reg;
    assign span      = newest_reg - ram_rdata;

    assign is_hit = (z_reg < thr_reg) &&
                    (!active_reg || (since_hit > {16'b0, holdoff_reg}));

    // A starting session writes from the ring's first slot
    assign wr_idx     = active_reg ? wpos_reg : '0;
    assign base_count = active_reg ? count_reg : '0;

    // Update due on a positive wrapped difference, with enough hits stored
    assign update_go = active_reg && (to_update != '0) && !to_update[hrm_pkg::TIME_W-1] &&
                       (count_reg > min_hits_reg) && (count_reg != '0);

    assign timed_out = active_reg && (since_hit > {16'b0, timeout_reg});

    assign newest_idx = (wpos_reg == '0) ? PW'(hrm_pkg::WINDOW_DEPTH - 1)
                                         : wpos_reg - PW'(1);
    assign oldest_idx = (CW'(wpos_reg) >= count_reg)
                      ? PW'(CW'(wpos_reg) - count_reg)
                      : PW'(CW'(wpos_reg) + CW'(hrm_pkg::WINDOW_DEPTH) - count_reg);

    // Saturation of divider results
    assign rate_sat = (div_rsp.quo > hrm_pkg::DIV_W'(16'hFFFF))
                    ? 16'hFFFF : div_rsp.quo[hrm_pkg::RATE_W-1:0];
    assign bar_sat  = (div_rsp.quo > hrm_pkg::DIV_W'(bar_len_reg))
                    ? bar_len_reg : div_rsp.quo[hrm_pkg::BAR_W-1:0];

    // Rate and bar land together; zero full scale gives a full bar
    assign commit_en  = ((state_reg == hrm_pkg::S_MUL) && (fs_reg == '0)) ||
                        ((state_reg == hrm_pkg::S_DIVB) && div_rsp.done);
    assign commit_bar = (state_reg == hrm_pkg::S_MUL) ? bar_len_reg : bar_sat;

    assign can_load = !m_tvalid_reg || m_tready;

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            hrm_pkg::S_IDLE:    if (s_tvalid) state_next = hrm_pkg::S_HIT;
            hrm_pkg::S_HIT:     state_next = hrm_pkg::S_CHK;
            hrm_pkg::S_CHK:     state_next = update_go ? hrm_pkg::S_RD_NEW : hrm_pkg::S_TMO;
            hrm_pkg::S_RD_NEW:  state_next = hrm_pkg::S_RD_OLD;
            hrm_pkg::S_RD_OLD:  state_next = (span == '0) ? hrm_pkg::S_TMO
                                                          : hrm_pkg::S_DIVR_GO;
            hrm_pkg::S_DIVR_GO: state_next = hrm_pkg::S_DIVR;
            hrm_pkg::S_DIVR:    if (div_rsp.done) state_next = hrm_pkg::S_MUL;
            hrm_pkg::S_MUL:     state_next = (fs_reg == '0) ? hrm_pkg::S_TMO
                                                            : hrm_pkg::S_DIVB_GO;
            hrm_pkg::S_DIVB_GO: state_next = hrm_pkg::S_DIVB;
            hrm_pkg::S_DIVB:    if (div_rsp.done) state_next = hrm_pkg::S_TMO;
            hrm_pkg::S_TMO:     state_next = hrm_pkg::S_OUT;
            hrm_pkg::S_OUT:     if (can_load) state_next = hrm_pkg::S_IDLE;
            default:            state_next = hrm_pkg::S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs and datapath
    // ------------------------------------------------------------------
    always_comb begin
        thr_next       = thr_reg;
        holdoff_next   = holdoff_reg;
        period_next    = period_reg;
        timeout_next   = timeout_reg;
        min_hits_next  = min_hits_reg;
        bar_len_next   = bar_len_reg;
        fs_next        = fs_reg;
        wpos_next      = wpos_reg;
        count_next     = count_reg;
        last_hit_next  = last_hit_reg;
        next_upd_next  = next_upd_reg;
        active_next    = active_reg;
        peak_next      = peak_reg;
        day_best_next  = day_best_reg;
        all_best_next  = all_best_reg;
        last_rate_next = last_rate_reg;
        last_bar_next  = last_bar_reg;
        hit_flag_next  = hit_flag_reg;
        upd_flag_next  = upd_flag_reg;
        end_flag_next  = end_flag_reg;
        kind_next      = kind_reg;
        krate_next     = krate_reg;
        z_next         = z_reg;
        now_next       = now_reg;
        newest_next    = newest_reg;
        rate_next      = rate_reg;
        div_num_next   = div_num_reg;
        div_den_next   = div_den_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;
        ram_we         = 1'b0;
        ram_waddr      = wr_idx;
        ram_raddr      = newest_idx;
        div_req.start  = 1'b0;
        div_req.num    = div_num_reg;
        div_req.den    = div_den_reg;

        // Register writes
        if (cfg_wr_en) begin
            case (cfg_addr)
                hrm_pkg::REG_HIT_THRESHOLD:    thr_next      = cfg_wdata;
                hrm_pkg::REG_HIT_HOLDOFF_MS:   holdoff_next  = cfg_wdata;
                hrm_pkg::REG_UPDATE_PERIOD_MS: period_next   = cfg_wdata;
                hrm_pkg::REG_HIT_TIMEOUT_MS:   timeout_next  = cfg_wdata;
                hrm_pkg::REG_MIN_HITS_TO_SHOW: min_hits_next = cfg_wdata[CW-1:0];
                hrm_pkg::REG_BAR_LENGTH:       bar_len_next  = cfg_wdata[hrm_pkg::BAR_W-1:0];
                hrm_pkg::REG_FULL_SCALE_RATE:  fs_next       = cfg_wdata;
                hrm_pkg::REG_STORED_BEST_RATE: all_best_next = cfg_wdata;
                default: ;
            endcase
        end

        case (state_reg)
            // Take the sample, clear the flags of the previous request
            hrm_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    z_next        = s_tdata[15:0];
                    now_next      = s_tdata[47:16];
                    hit_flag_next = 1'b0;
                    upd_flag_next = 1'b0;
                    end_flag_next = 1'b0;
                    kind_next     = hrm_pkg::REC_NONE;
                    krate_next    = '0;
                end
            end
            // Hit detection, session start and ring write
            hrm_pkg::S_HIT: begin
                if (is_hit) begin
                    if (!active_reg) begin
                        active_next    = 1'b1;
                        peak_next      = '0;
                        last_rate_next = '0;
                        last_bar_next  = '0;
                        next_upd_next  = now_reg + {16'b0, period_reg};
                    end
                    hit_flag_next = 1'b1;
                    last_hit_next = now_reg;
                    ram_we        = 1'b1;
                    count_next    = (base_count < CW'(hrm_pkg::WINDOW_DEPTH))
                                  ? base_count + CW'(1) : base_count;
                    wpos_next     = (wr_idx == PW'(hrm_pkg::WINDOW_DEPTH - 1))
                                  ? '0 : wr_idx + PW'(1);
                end
            end
            // Newest read issued; rate numerator prepared
            hrm_pkg::S_CHK: begin
                ram_raddr    = newest_idx;
                div_num_next = hrm_pkg::DIV_W'(hrm_pkg::RATE_SCALE) *
                               hrm_pkg::DIV_W'(count_reg);
            end
            hrm_pkg::S_RD_NEW: begin
                newest_next = ram_rdata;
                ram_raddr   = oldest_idx;
            end
            hrm_pkg::S_RD_OLD: begin
                div_den_next = span;
            end
            hrm_pkg::S_DIVR_GO: begin
                div_req.start = 1'b1;
            end
            hrm_pkg::S_DIVR: begin
                if (div_rsp.done) begin
                    rate_next = rate_sat;
                end
            end
            // Bar numerator and full-scale divisor
            hrm_pkg::S_MUL: begin
                div_num_next = hrm_pkg::DIV_W'(bar_len_reg) * hrm_pkg::DIV_W'(rate_reg);
                div_den_next = hrm_pkg::DEN_W'(fs_reg);
            end
            hrm_pkg::S_DIVB_GO: begin
                div_req.start = 1'b1;
            end
            hrm_pkg::S_DIVB: ;
            // Session timeout and records
            hrm_pkg::S_TMO: begin
                if (timed_out) begin
                    end_flag_next = 1'b1;
                    active_next   = 1'b0;
                    if (count_reg == CW'(hrm_pkg::WINDOW_DEPTH)) begin
                        if (peak_reg > all_best_reg) begin
                            all_best_next = peak_reg;
                            day_best_next = peak_reg;
                            kind_next     = hrm_pkg::REC_ALL;
                            krate_next    = peak_reg;
                        end else if (peak_reg > day_best_reg) begin
                            day_best_next = peak_reg;
                            kind_next     = hrm_pkg::REC_DAY;
                            krate_next    = peak_reg;
                        end
                    end
                end
            end
            // Hand the result to the output register
            hrm_pkg::S_OUT: begin
                if (can_load) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {
                        (hrm_pkg::M_TDATA_W - hrm_pkg::M_USED_W)'(0),
                        krate_reg, end_flag_reg, last_bar_reg, last_rate_reg,
                        upd_flag_reg, hit_flag_reg
                    };
                    m_tuser_next  = kind_reg;
                end
            end
            default: ;
        endcase

        // Rate and bar commit, peak tracking on a full ring, reschedule
        if (commit_en) begin
            last_rate_next = rate_reg;
            last_bar_next  = commit_bar;
            upd_flag_next  = 1'b1;
            next_upd_next  = now_reg + {16'b0, period_reg};
            if ((count_reg == CW'(hrm_pkg::WINDOW_DEPTH)) && (rate_reg > peak_reg)) begin
                peak_next = rate_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Control and configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= hrm_pkg::S_IDLE;
            thr_reg       <= hrm_pkg::HIT_THRESHOLD_RST;
            holdoff_reg   <= hrm_pkg::HIT_HOLDOFF_RST;
            period_reg    <= hrm_pkg::UPDATE_PERIOD_RST;
            timeout_reg   <= hrm_pkg::HIT_TIMEOUT_RST;
            min_hits_reg  <= hrm_pkg::MIN_HITS_RST;
            bar_len_reg   <= hrm_pkg::BAR_LENGTH_RST;
            fs_reg        <= hrm_pkg::FULL_SCALE_RST;
            wpos_reg      <= '0;
            count_reg     <= '0;
            last_hit_reg  <= '0;
            next_upd_reg  <= '0;
            active_reg    <= 1'b0;
            peak_reg      <= '0;
            day_best_reg  <= '0;
            all_best_reg  <= hrm_pkg::STORED_BEST_RST;
            last_rate_reg <= '0;
            last_bar_reg  <= '0;
            hit_flag_reg  <= 1'b0;
            upd_flag_reg  <= 1'b0;
            end_flag_reg  <= 1'b0;
            kind_reg      <= hrm_pkg::REC_NONE;
            krate_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            thr_reg       <= thr_next;
            holdoff_reg   <= holdoff_next;
            period_reg    <= period_next;
            timeout_reg   <= timeout_next;
            min_hits_reg  <= min_hits_next;
            bar_len_reg   <= bar_len_next;
            fs_reg        <= fs_next;
            wpos_reg      <= wpos_next;
            count_reg     <= count_next;
            last_hit_reg  <= last_hit_next;
            next_upd_reg  <= next_upd_next;
            active_reg    <= active_next;
            peak_reg      <= peak_next;
            day_best_reg  <= day_best_next;
            all_best_reg  <= all_best_next;
            last_rate_reg <= last_rate_next;
            last_bar_reg  <= last_bar_next;
            hit_flag_reg  <= hit_flag_next;
            upd_flag_reg  <= upd_flag_next;
            end_flag_reg  <= end_flag_next;
            kind_reg      <= kind_next;
            krate_reg     <= krate_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        z_reg       <= z_next;
        now_reg     <= now_next;
        newest_reg  <= newest_next;
        rate_reg    <= rate_next;
        div_num_reg <= div_num_next;
        div_den_reg <= div_den_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign s_tready = (state_reg == hrm_pkg::S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

### rtl/core/hrm_checker.sv
// ============================================================================
// Hit rate meter - port checker
// Watches the stream ports of the top level over time.
// ============================================================================
`include "hit_rate_meter_unit_defines.svh"

module hrm_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [hrm_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [hrm_pkg::M_TUSER_W-1:0]  m_tuser
);

    // A stalled result holds
    `HRM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // The block is not ready in the cycle after taking a request
    `HRM_ASSERT_NEXT(a_busy_after_req, s_tvalid && s_tready, !s_tready, "ready straight after a request")

    // A hit in this sample cannot also time the session out
    `HRM_ASSERT_NOW(a_hit_no_end, m_tvalid && m_tdata[0], !m_tdata[26], "hit and session end together")

    // A record is only reported when the session ends
    `HRM_ASSERT_NOW(a_rec_needs_end, m_tvalid && (m_tuser != 2'd0), m_tdata[26], "record without session end")

    // No record means a zero record rate
    `HRM_ASSERT_NOW(a_no_rec_zero, m_tvalid && (m_tuser == 2'd0), m_tdata[42:27] == 16'd0, "record rate without record")

endmodule

bind hit_rate_meter_unit hrm_checker u_hrm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
